/* sv/sts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// types and constants shared by the token scanner and its checker
// ----------------------------------------------------------------------------
package sts_pkg;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_INT    = 3'd1,
		M_FRAC   = 3'd2,
		M_WORD   = 3'd3,
		M_IDENT  = 3'd4,
		M_STRING = 3'd5
	} mode_t;

	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_ERROR   = 6'd1;
	localparam logic [5:0] K_INT     = 6'd2;
	localparam logic [5:0] K_FLOAT   = 6'd3;
	localparam logic [5:0] K_IDENT   = 6'd4;
	localparam logic [5:0] K_STRING  = 6'd5;
	localparam logic [5:0] K_NEWLINE = 6'd45;
	localparam logic [5:0] K_MAX     = 6'd45;

	localparam int unsigned TOKEN_BITS = 6 + 16 + 16 + 16;

	typedef struct packed {
		logic [15:0] line_number;
		logic [15:0] token_len;
		logic [15:0] start_pos;
		logic [5:0]  token_kind;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
	endfunction

	function automatic logic [5:0] single_op(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			8'h28: k = 6'd22;
			8'h29: k = 6'd23;
			8'h7b: k = 6'd24;
			8'h7d: k = 6'd25;
			8'h2e: k = 6'd26;
			8'h2b: k = 6'd27;
			8'h2d: k = 6'd28;
			8'h2a: k = 6'd29;
			8'h2f: k = 6'd30;
			8'h3b: k = 6'd31;
			8'h3a: k = 6'd32;
			8'h2c: k = 6'd33;
			8'h21: k = 6'd35;
			8'h3d: k = 6'd37;
			8'h3e: k = 6'd40;
			8'h3c: k = 6'd43;
			8'h09: k = 6'd44;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] double_op(input logic [7:0] p, input logic [7:0] c);
		logic [5:0] k;
		k = 6'd0;
		if (p == 8'h21 && c == 8'h3d) k = 6'd34;
		if (p == 8'h3d && c == 8'h3d) k = 6'd36;
		if (p == 8'h3e && c == 8'h3d) k = 6'd38;
		if (p == 8'h3e && c == 8'h3e) k = 6'd39;
		if (p == 8'h3c && c == 8'h3d) k = 6'd41;
		if (p == 8'h3c && c == 8'h3c) k = 6'd42;
		return k;
	endfunction

	// word packed with first letter in the lowest byte
	function automatic logic [5:0] keyword_kind(input logic [63:0] w, input logic [3:0] n);
		logic [5:0] k;
		k = 6'd0;
		unique case (n)
			4'd2: if (w[15:0] == "fi") k = 6'd7;
			4'd3: begin
				if (w[23:0] == "tni") k = 6'd6;
				else if (w[23:0] == "fed") k = 6'd12;
				else if (w[23:0] == "rof") k = 6'd15;
			end
			4'd4: begin
				if (w[31:0] == "loob") k = 6'd8;
				else if (w[31:0] == "rahc") k = 6'd10;
				else if (w[31:0] == "esle") k = 6'd14;
				else if (w[31:0] == "eurt") k = 6'd17;
			end
			4'd5: begin
				if (w[39:0] == "kaerb") k = 6'd9;
				else if (w[39:0] == "taolf") k = 6'd16;
				else if (w[39:0] == "eslaf") k = 6'd17;
				else if (w[39:0] == "elihw") k = 6'd21;
			end
			4'd6: begin
				if (w[47:0] == "elbuod") k = 6'd13;
				else if (w[47:0] == "nruter") k = 6'd18;
				else if (w[47:0] == "gnirts") k = 6'd19;
				else if (w[47:0] == "tcurts") k = 6'd20;
			end
			4'd8: if (w == "eunitnoc") k = 6'd11;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

endpackage

/* sv/source_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner
// byte-serial lexical scanner emitting kind, offset, length and line per token
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: char_byte[7:0]; tuser: end_of_text
// m_axis   out  tdata: token_kind, start_pos, token_len, line_number; tlast
//
// one byte per cycle; a byte yields up to two tokens, held in a two-entry
// output queue, and the next byte is taken once the queue has room for two.
// scanner state updates in the cycle the byte is accepted.
// arst_n clears all control state; the line counter restarts at one.
// end of text flushes a pending token, emits eof and returns to reset state.
// ----------------------------------------------------------------------------
module source_token_scanner #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // char_byte[7:0]
	input  logic        s_axis_tuser,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // token_kind[5:0], start_pos[21:6],
	                                    // token_len[37:22], line_number[53:38]
	output logic        m_axis_tlast
);

	localparam int CNT_BITS = $clog2(KEYWORD_CHARS + 2);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	sts_pkg::mode_t mode_q, mode_d;
	logic [7:0] letters_q [KEYWORD_CHARS];
	logic [CNT_BITS-1:0] count_q, count_d;
	logic [POSITION_BITS-1:0] pos_q, begin_q, begin_d;
	logic [15:0] line_q, line_d;
	logic [7:0] pend_q, pend_d;
	logic halt_q, halt_d;
	logic wr_letter;
	logic [CNT_BITS-1:0] wr_idx;

	sts_pkg::token_t tok [2];
	logic [1:0] ntok;

	sts_pkg::token_t q_tok [2];
	logic q_last [2];
	logic [1:0] q_cnt;

	logic acc, pop;
	logic [7:0] c;
	logic eot;
	logic [POSITION_BITS-1:0] run;
	logic [63:0] word;
	logic [5:0] kw;

	assign c = s_axis_tdata;
	assign eot = s_axis_tuser;
	assign run = pos_q - begin_q;
	assign s_axis_tready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && pop);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_comb begin
		word = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < KEYWORD_CHARS) word[i*8 +: 8] = letters_q[i];
		end
		if (count_q > CNT_BITS'(KEYWORD_CHARS) || count_q > CNT_BITS'(8))
			kw = 6'd0;
		else
			kw = sts_pkg::keyword_kind(word, 4'(count_q));
	end

	function automatic logic [15:0] sat(input logic [POSITION_BITS:0] v);
		return (v > (POSITION_BITS+1)'(16'hffff)) ? 16'hffff : 16'(v);
	endfunction

	always_comb begin
		logic rescan;
		logic [5:0] k;
		mode_d = mode_q;
		count_d = count_q;
		begin_d = begin_q;
		line_d = line_q;
		pend_d = pend_q;
		halt_d = halt_q;
		wr_letter = 1'b0;
		wr_idx = count_q;
		ntok = 2'd0;
		rescan = 1'b0;
		k = 6'd0;
		for (int i = 0; i < 2; i++) tok[i] = '0;
		if (eot) begin
			if (!halt_q) begin
				if (pend_q != 8'd0) begin
					tok[0] = {line_q, 16'd1, sat({1'b0, begin_q}),
						sts_pkg::single_op(pend_q)};
					ntok = 2'd1;
				end else if (mode_q != sts_pkg::M_IDLE) begin
					unique case (mode_q)
						sts_pkg::M_INT:    k = sts_pkg::K_INT;
						sts_pkg::M_FRAC:   k = sts_pkg::K_FLOAT;
						sts_pkg::M_WORD:   k = (kw != 6'd0) ? kw : sts_pkg::K_IDENT;
						sts_pkg::M_IDENT:  k = sts_pkg::K_IDENT;
						default:           k = sts_pkg::K_ERROR;
					endcase
					tok[0] = {line_q, sat({1'b0, run}), sat({1'b0, begin_q}), k};
					ntok = 2'd1;
				end
			end
			tok[ntok[0]] = {line_q, 16'd0, sat({1'b0, pos_q}), sts_pkg::K_EOF};
			ntok = ntok + 2'd1;
			mode_d = sts_pkg::M_IDLE;
			count_d = '0;
			begin_d = '0;
			line_d = 16'd1;
			pend_d = 8'd0;
			halt_d = 1'b0;
		end else if (!halt_q) begin
			if (pend_q != 8'd0) begin
				k = sts_pkg::double_op(pend_q, c);
				if (k != 6'd0) begin
					tok[0] = {line_q, 16'd2, sat({1'b0, begin_q}), k};
				end else begin
					tok[0] = {line_q, 16'd1, sat({1'b0, begin_q}),
						sts_pkg::single_op(pend_q)};
					rescan = 1'b1;
				end
				ntok = 2'd1;
				pend_d = 8'd0;
			end else begin
				unique case (mode_q)
					sts_pkg::M_INT: begin
						if (c == 8'h2e) mode_d = sts_pkg::M_FRAC;
						else if (!sts_pkg::is_digit(c)) begin
							tok[0] = {line_q, sat({1'b0, run}), sat({1'b0, begin_q}),
								sts_pkg::K_INT};
							ntok = 2'd1;
							rescan = 1'b1;
						end
					end
					sts_pkg::M_FRAC: begin
						if (!sts_pkg::is_digit(c)) begin
							tok[0] = {line_q, sat({1'b0, run}), sat({1'b0, begin_q}),
								sts_pkg::K_FLOAT};
							ntok = 2'd1;
							rescan = 1'b1;
						end
					end
					sts_pkg::M_WORD: begin
						if (sts_pkg::is_letter(c)) begin
							wr_letter = count_q < CNT_BITS'(KEYWORD_CHARS);
							if (count_q <= CNT_BITS'(KEYWORD_CHARS))
								count_d = count_q + 1'b1;
						end else if (sts_pkg::is_digit(c) && kw == 6'd0) begin
							mode_d = sts_pkg::M_IDENT;
						end else begin
							tok[0] = {line_q, sat({1'b0, run}), sat({1'b0, begin_q}),
								(kw != 6'd0) ? kw : sts_pkg::K_IDENT};
							ntok = 2'd1;
							rescan = 1'b1;
						end
					end
					sts_pkg::M_IDENT: begin
						if (!sts_pkg::is_letter(c) && !sts_pkg::is_digit(c)) begin
							tok[0] = {line_q, sat({1'b0, run}), sat({1'b0, begin_q}),
								sts_pkg::K_IDENT};
							ntok = 2'd1;
							rescan = 1'b1;
						end
					end
					sts_pkg::M_STRING: begin
						if (c == 8'h22 || c == 8'h20 || c == 8'h0a) begin
							tok[0] = {line_q, sat({1'b0, run} + 1'b1),
								sat({1'b0, begin_q}),
								(c == 8'h22) ? sts_pkg::K_STRING : sts_pkg::K_ERROR};
							ntok = 2'd1;
							mode_d = sts_pkg::M_IDLE;
							halt_d = (c != 8'h22);
						end
					end
					default: rescan = 1'b1;
				endcase
			end
			if (rescan) begin
				mode_d = sts_pkg::M_IDLE;
				if (c != 8'h20) begin
					begin_d = pos_q;
					priority if (sts_pkg::is_digit(c)) begin
						mode_d = sts_pkg::M_INT;
					end else if (sts_pkg::is_letter(c)) begin
						wr_letter = 1'b1;
						wr_idx = '0;
						count_d = CNT_BITS'(1);
						mode_d = sts_pkg::M_WORD;
					end else if (c == 8'h22) begin
						mode_d = sts_pkg::M_STRING;
					end else if (c == 8'h21 || c == 8'h3d || c == 8'h3c || c == 8'h3e) begin
						pend_d = c;
					end else if (c == 8'h0a) begin
						if (line_q != 16'hffff) line_d = line_q + 16'd1;
						tok[ntok[0]] = {line_d, 16'd1, sat({1'b0, pos_q}),
							sts_pkg::K_NEWLINE};
						ntok = ntok + 2'd1;
					end else if (sts_pkg::single_op(c) != 6'd0) begin
						tok[ntok[0]] = {line_q, 16'd1, sat({1'b0, pos_q}),
							sts_pkg::single_op(c)};
						ntok = ntok + 2'd1;
					end else begin
						tok[ntok[0]] = {line_q, 16'd1, sat({1'b0, pos_q}),
							sts_pkg::K_ERROR};
						ntok = ntok + 2'd1;
						halt_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::M_IDLE;
			count_q <= '0;
			pos_q <= '0;
			begin_q <= '0;
			line_q <= 16'd1;
			pend_q <= 8'd0;
			halt_q <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d;
			count_q <= count_d;
			begin_q <= begin_d;
			line_q <= line_d;
			pend_q <= pend_d;
			halt_q <= halt_d;
			if (eot) pos_q <= '0;
			else if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !eot && wr_letter)
			letters_q[wr_idx[$clog2(KEYWORD_CHARS)-1:0]] <= c;
	end

	// two-entry output queue; entry 0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt <= 2'd0;
		end else begin
			q_cnt <= q_cnt - {1'b0, pop} + (acc ? ntok : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		logic [1:0] base;
		base = q_cnt - {1'b0, pop};
		if (pop && q_cnt == 2'd2) begin
			q_tok[0] <= q_tok[1];
			q_last[0] <= q_last[1];
		end
		if (acc) begin
			for (int i = 0; i < 2; i++) begin
				if (2'(i) < ntok) begin
					q_tok[base[0] + i[0]] <= tok[i];
					q_last[base[0] + i[0]] <= (2'(i) == ntok - 2'd1);
				end
			end
		end
	end

	assign m_axis_tvalid = q_cnt != 2'd0;
	assign m_axis_tdata = {2'b00, q_tok[0]};
	assign m_axis_tlast = q_last[0];

endmodule

/* sv/sts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks on the token scanner
// ----------------------------------------------------------------------------
module sts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled token changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[5:0] <= sts_pkg::K_MAX)
		else $error("token kind out of range");

	// eof always closes its run
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5:0] == sts_pkg::K_EOF |-> m_axis_tlast)
		else $error("eof without tlast");

	a_eof_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5:0] == sts_pkg::K_EOF |-> m_axis_tdata[37:22] == 16'd0)
		else $error("eof with nonzero length");

	// no input taken while output queue is full and stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("input accepted while queue full");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
